FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

FILE: rtl/irpde_pkg.sv
// Types and constants of the IR pulse-distance encoder.
// Used by the front end, queue, back end and top level of the block; depends on nothing.
package irpde_pkg;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	// segment positions within one item's run
	localparam step_t STEP_HDR_MARK  = 5'd0;
	localparam step_t STEP_HDR_SPACE = 5'd1;
	localparam step_t STEP_BIT_FIRST = 5'd2;
	localparam step_t STEP_BIT_LAST  = 5'd17;
	localparam step_t STEP_TRAIL     = 5'd18;

	localparam int REG_W = 16;
	typedef logic [REG_W-1:0] reg_t;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_SHORT     = 2'd0;
	localparam logic [1:0] REG_LONG      = 2'd1;
	localparam logic [1:0] REG_HDR_MARK  = 2'd2;
	localparam logic [1:0] REG_HDR_SPACE = 2'd3;

	localparam reg_t SHORT_RESET     = 16'd560;
	localparam reg_t LONG_RESET      = 16'd1690;
	localparam reg_t HDR_MARK_RESET  = 16'd3000;
	localparam reg_t HDR_SPACE_RESET = 16'd2000;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
		step_t      start;
	} cmd_t;

	typedef struct packed {
		reg_t short_time;
		reg_t long_time;
		reg_t header_mark_time;
		reg_t header_space_time;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: rtl/irpde_front.sv
// Front end: accepts input beats, drops empty items, picks the first segment.
// Depends on irpde_pkg; feeds irpde_cmd_fifo.
module irpde_front import irpde_pkg::*; (
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       first_of_frame,
	input  logic       last_of_frame,
	input  q_status_t  q_status,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic has_work;

	assign full     = q_status.full;
	assign has_work = byte_present | first_of_frame | last_of_frame;
	assign q_push   = push & ~q_status.full & has_work;

	always_comb begin
		q_cmd.data    = data_byte;
		q_cmd.present = byte_present;
		q_cmd.last    = last_of_frame;
		if (first_of_frame) begin
			q_cmd.start = STEP_HDR_MARK;
		end else if (byte_present) begin
			q_cmd.start = STEP_BIT_FIRST;
		end else begin
			q_cmd.start = STEP_TRAIL;
		end
	end

endmodule

FILE: rtl/irpde_cmd_fifo.sv
// Two-entry command queue between the front end and the segment sequencer.
// Depends on irpde_pkg.
module irpde_cmd_fifo import irpde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  cmd_t      wr_cmd,
	input  logic      rd_en,
	output cmd_t      rd_cmd,
	output q_status_t status
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign do_wr        = wr_en & ~status.full;
	assign do_rd        = rd_en & ~status.empty;
	assign rd_cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/irpde_back.sv
// Back end: steps through one command's segments, one beat a cycle unless the output is stalled,
// into the output register. Depends on irpde_pkg; reads irpde_cmd_fifo.
module irpde_back import irpde_pkg::*; #(
	parameter int DURATION_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  q_status_t                 q_status,
	input  cmd_t                      q_cmd,
	output logic                      q_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic                      carrier_on,
	output logic [DURATION_WIDTH-1:0] duration_us,
	output logic                      run_end,
	output logic                      frame_end
);

	localparam logic [31:0] DUR_MAX = (DURATION_WIDTH >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << DURATION_WIDTH) - 32'd1);

	logic                      active_q;
	step_t                     step_q;
	logic [7:0]                data_q;
	logic                      present_q;
	logic                      last_q;
	logic                      out_valid_q;
	logic                      carrier_q;
	logic [DURATION_WIDTH-1:0] dur_q;
	logic                      run_end_q;
	logic                      frame_end_q;

	logic                      out_ready;
	logic                      emit;
	logic                      seg_last;
	logic                      load;
	step_t                     step_next;
	step_t                     bit_off;
	reg_t                      raw_dur;
	logic [DURATION_WIDTH-1:0] seg_dur;

	assign out_ready = ~out_valid_q | pop;
	assign emit      = active_q & out_ready;
	assign seg_last  = (step_q == STEP_TRAIL) ||
		(step_q == STEP_BIT_LAST && !last_q) ||
		(step_q == STEP_HDR_SPACE && !present_q && !last_q);
	assign load      = ~q_status.empty & (~active_q | (emit & seg_last));
	assign q_pop     = load;
	assign bit_off   = step_q - STEP_BIT_FIRST;

	always_comb begin
		if (step_q == STEP_HDR_SPACE) begin
			step_next = present_q ? STEP_BIT_FIRST : STEP_TRAIL;
		end else if (step_q == STEP_BIT_LAST) begin
			step_next = STEP_TRAIL;
		end else begin
			step_next = step_q + step_t'(1);
		end
	end

	always_comb begin
		if (step_q == STEP_HDR_MARK) begin
			raw_dur = cfg.header_mark_time;
		end else if (step_q == STEP_HDR_SPACE) begin
			raw_dur = cfg.header_space_time;
		end else if (step_q == STEP_TRAIL) begin
			raw_dur = cfg.long_time;
		end else if (step_q[0] && data_q[bit_off[3:1]]) begin
			raw_dur = cfg.long_time;
		end else begin
			raw_dur = cfg.short_time;
		end
		if ({16'd0, raw_dur} > DUR_MAX) begin
			seg_dur = DURATION_WIDTH'(DUR_MAX);
		end else begin
			seg_dur = DURATION_WIDTH'(raw_dur);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q    <= q_cmd.data;
			present_q <= q_cmd.present;
			last_q    <= q_cmd.last;
		end
		if (emit) begin
			carrier_q   <= ~step_q[0];
			dur_q       <= seg_dur;
			run_end_q   <= seg_last;
			frame_end_q <= (step_q == STEP_TRAIL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= STEP_HDR_MARK;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				step_q   <= q_cmd.start;
			end else if (emit) begin
				if (seg_last) begin
					active_q <= 1'b0;
				end else begin
					step_q <= step_next;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty       = ~out_valid_q;
	assign carrier_on  = carrier_q;
	assign duration_us = dur_q;
	assign run_end     = run_end_q;
	assign frame_end   = frame_end_q;

endmodule

FILE: rtl/ir_pulse_distance_encoder.sv
// IR pulse-distance encoder: frame items in, mark/space segments out, one beat a cycle unless stalled.
// An accepted item passes through the command queue and the sequencer's step register to the output register.
// Throughput: 2 + 16 + 1 segments per item at most, one per cycle from the sequencer unless the result side stalls;
// the single segment sequencer in irpde_back emits them while the queue takes further items.
// Reset: arst_n clears queue and sequencer and restores the default timing registers.
// Depends on irpde_pkg, irpde_front, irpde_cmd_fifo, irpde_back.
module ir_pulse_distance_encoder import irpde_pkg::*; #(
	parameter int DURATION_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                data_byte,
	input  logic                      byte_present,
	input  logic                      first_of_frame,
	input  logic                      last_of_frame,
	output logic                      empty,
	input  logic                      pop,
	output logic                      carrier_on,
	output logic [DURATION_WIDTH-1:0] duration_us,
	output logic                      run_end,
	output logic                      frame_end
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	q_status_t  q_status;
	logic       q_push;
	cmd_t       q_wr_cmd;
	logic       q_pop;
	cmd_t       q_rd_cmd;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_time        <= SHORT_RESET;
			cfg_q.long_time         <= LONG_RESET;
			cfg_q.header_mark_time  <= HDR_MARK_RESET;
			cfg_q.header_space_time <= HDR_SPACE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SHORT:     cfg_q.short_time        <= pwdata[REG_W-1:0];
				REG_LONG:      cfg_q.long_time         <= pwdata[REG_W-1:0];
				REG_HDR_MARK:  cfg_q.header_mark_time  <= pwdata[REG_W-1:0];
				REG_HDR_SPACE: cfg_q.header_space_time <= pwdata[REG_W-1:0];
				default:       cfg_q                   <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SHORT:     prdata = {16'd0, cfg_q.short_time};
			REG_LONG:      prdata = {16'd0, cfg_q.long_time};
			REG_HDR_MARK:  prdata = {16'd0, cfg_q.header_mark_time};
			REG_HDR_SPACE: prdata = {16'd0, cfg_q.header_space_time};
			default:       prdata = 32'd0;
		endcase
	end

	irpde_front u_front (
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.q_status       (q_status),
		.q_push         (q_push),
		.q_cmd          (q_wr_cmd)
	);

	irpde_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_cmd (q_wr_cmd),
		.rd_en  (q_pop),
		.rd_cmd (q_rd_cmd),
		.status (q_status)
	);

	irpde_back #(
		.DURATION_WIDTH (DURATION_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_status    (q_status),
		.q_cmd       (q_rd_cmd),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.carrier_on  (carrier_on),
		.duration_us (duration_us),
		.run_end     (run_end),
		.frame_end   (frame_end)
	);

endmodule

FILE: rtl/irpde_chk.sv
// Port-level checker for the IR pulse-distance encoder, bound to the top level.
// Depends on assert_macros.svh and ir_pulse_distance_encoder.
`include "assert_macros.svh"
module irpde_chk #(
	parameter int DURATION_WIDTH = 16
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      pready,
	input logic                      empty,
	input logic                      pop,
	input logic                      carrier_on,
	input logic [DURATION_WIDTH-1:0] duration_us,
	input logic                      run_end,
	input logic                      frame_end
);

	// trailing mark closes the run
	`ASSERT_IMPLY(a_frame_end_mark, clk, arst_n, !empty && frame_end, carrier_on && run_end)
	`ASSERT_IMPLY(a_pready_high, clk, arst_n, 1'b1, pready)
	// segments within a run follow without a gap
	`ASSERT_NEXT(a_run_no_gap, clk, arst_n, !empty && pop && !run_end, !empty)
	// a space is always followed by a mark
	`ASSERT_NEXT(a_space_then_mark, clk, arst_n, !empty && pop && !carrier_on, empty || carrier_on)
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, !empty && !pop, !empty && $stable(duration_us))

endmodule

bind ir_pulse_distance_encoder irpde_chk #(
	.DURATION_WIDTH (DURATION_WIDTH)
) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.pready      (pready),
	.empty       (empty),
	.pop         (pop),
	.carrier_on  (carrier_on),
	.duration_us (duration_us),
	.run_end     (run_end),
	.frame_end   (frame_end)
);

FILE: sim/tb_ir_pulse_distance_encoder.sv
// Testbench for ir_pulse_distance_encoder: drives frame items and timing registers,
// predicts every mark/space segment and checks each result beat in order.
// Depends on irpde_pkg and the RTL of the block.
`timescale 1ns / 1ps

import irpde_pkg::*;

typedef struct {
	logic [7:0] data;
	logic       present;
	logic       first;
	logic       last;
} frame_item_t;

typedef struct {
	logic carrier;
	reg_t dur;
	logic run_end;
	logic frame_end;
} segment_t;

class ir_segment_board;
	cfg_t        timing;
	segment_t    segs_due[$];
	int unsigned errors;

	function new();
		timing.short_time        = SHORT_RESET;
		timing.long_time         = LONG_RESET;
		timing.header_mark_time  = HDR_MARK_RESET;
		timing.header_space_time = HDR_SPACE_RESET;
		errors = 0;
	endfunction

	function void set_timing(logic [1:0] idx, reg_t val);
		case (idx)
			REG_SHORT:     timing.short_time = val;
			REG_LONG:      timing.long_time = val;
			REG_HDR_MARK:  timing.header_mark_time = val;
			REG_HDR_SPACE: timing.header_space_time = val;
			default:       ;
		endcase
	endfunction

	function int pending();
		return segs_due.size();
	endfunction

	function void add_seg(logic carrier, reg_t dur, logic fend, logic closes_run);
		segment_t s;
		s.carrier   = carrier;
		s.dur       = dur;
		s.run_end   = closes_run;
		s.frame_end = fend;
		segs_due.push_back(s);
	endfunction

	// segments caused by one accepted item
	function void note_item(frame_item_t it);
		int n;
		int k;
		n = (it.first ? 2 : 0) + (it.present ? 16 : 0) + (it.last ? 1 : 0);
		k = 0;
		if (it.first) begin
			k++; add_seg(1'b1, timing.header_mark_time, 1'b0, k == n);
			k++; add_seg(1'b0, timing.header_space_time, 1'b0, k == n);
		end
		if (it.present) begin
			for (int i = 0; i < 8; i++) begin
				k++; add_seg(1'b1, timing.short_time, 1'b0, k == n);
				k++; add_seg(1'b0, it.data[i] ? timing.long_time : timing.short_time, 1'b0, k == n);
			end
		end
		if (it.last) begin
			k++; add_seg(1'b1, timing.long_time, 1'b1, k == n);
		end
	endfunction

	function void check_segment(segment_t got);
		segment_t want;
		if (segs_due.size() == 0) begin
			$error("segment beat with nothing outstanding: carrier_on %0d duration_us %0d",
				got.carrier, got.dur);
			errors++;
			return;
		end
		want = segs_due.pop_front();
		if (got.carrier !== want.carrier) begin
			$error("carrier_on: expected %0d, got %0d", want.carrier, got.carrier);
			errors++;
		end
		if (got.dur !== want.dur) begin
			$error("duration_us: expected %0d, got %0d", want.dur, got.dur);
			errors++;
		end
		if (got.run_end !== want.run_end) begin
			$error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
			errors++;
		end
		if (got.frame_end !== want.frame_end) begin
			$error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
			errors++;
		end
	endfunction
endclass

module tb_ir_pulse_distance_encoder;

	localparam int LONG_HOLD = 400;
	localparam int SETTLE    = 24;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              push;
	logic              full;
	logic [7:0]        data_byte;
	logic              byte_present;
	logic              first_of_frame;
	logic              last_of_frame;
	logic              empty;
	logic              pop;
	logic              carrier_on;
	logic [15:0]       duration_us;
	logic              run_end;
	logic              frame_end;

	ir_segment_board board;
	bit              calm;
	bit              hold_pending;
	int unsigned     items_sent;

	ir_pulse_distance_encoder #(.DURATION_WIDTH(16)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.data_byte(data_byte), .byte_present(byte_present),
		.first_of_frame(first_of_frame), .last_of_frame(last_of_frame),
		.empty(empty), .pop(pop),
		.carrier_on(carrier_on), .duration_us(duration_us),
		.run_end(run_end), .frame_end(frame_end)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic send_item(logic [7:0] d, logic p, logic f, logic l);
		frame_item_t it;
		it.data = d; it.present = p; it.first = f; it.last = l;
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push           <= 1'b1;
		data_byte      <= d;
		byte_present   <= p;
		first_of_frame <= f;
		last_of_frame  <= l;
		do @(posedge clk); while (full);
		board.note_item(it);
		if (p || f || l)
			items_sent++;
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, reg_t val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_timing(idx, val);
	endtask

	task automatic set_phase(reg_t s, reg_t l, reg_t hm, reg_t hs);
		wait_drain();
		reg_write(REG_SHORT, s);
		reg_write(REG_LONG, l);
		reg_write(REG_HDR_MARK, hm);
		reg_write(REG_HDR_SPACE, hs);
	endtask

	task automatic send_frame();
		int nbytes;
		nbytes = $urandom_range(0, 4);
		if (nbytes == 0) begin
			if ($urandom_range(0, 1) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b1, 1'b1);
			end else begin
				send_item(8'($urandom), 1'b0, 1'b1, 1'b0);
				send_item(8'($urandom), 1'b0, 1'b0, 1'b1);
			end
		end else begin
			for (int i = 0; i < nbytes; i++)
				send_item(8'($urandom), 1'b1, i == 0, i == nbytes - 1);
		end
	endtask

	task automatic run_traffic(int unsigned n_items);
		int unsigned start;
		logic [3:0]  flags;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(0, 4) == 0) begin
				flags = 4'($urandom);
				send_item(8'($urandom), flags[0], flags[1], flags[2]);
			end else begin
				send_frame();
			end
		end
	endtask

	// result side: random stalls, long hold on request
	initial begin
		int stall_left;
		segment_t got;
		stall_left = 0;
		pop <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.carrier   = carrier_on;
				got.dur       = duration_us;
				got.run_end   = run_end;
				got.frame_end = frame_end;
				board.check_segment(got);
			end
			if (hold_pending) begin
				hold_pending = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		board = new();
		calm = 1'b0;
		hold_pending = 1'b0;
		items_sent = 0;
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		push           <= 1'b0;
		data_byte      <= '0;
		byte_present   <= 1'b0;
		first_of_frame <= 1'b0;
		last_of_frame  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset timing
		send_item(8'h5A, 1'b0, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0, 1'b0);
		send_item(8'hC3, 1'b0, 1'b0, 1'b1);
		send_item(8'h01, 1'b1, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0, 1'b0);
		send_item(8'hA5, 1'b1, 1'b0, 1'b1);
		send_item(8'h3C, 1'b1, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(8'h55, 1'b0, 1'b0, 1'b1);
		send_item(8'hAA, 1'b1, 1'b0, 1'b1);
		send_item(8'h7E, 1'b0, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0, 1'b1);

		set_phase(16'd0, 16'd0, 16'd0, 16'd0);
		send_item(8'h96, 1'b1, 1'b1, 1'b1);
		run_traffic(50);

		set_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		hold_pending = 1'b1;
		run_traffic(52);

		set_phase(16'd1, 16'hFFFF, 16'd0, 16'h8000);
		run_traffic(26);
		wait_drain();
		run_traffic(26);

		set_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_traffic(52);

		set_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_traffic(52);

		set_phase(SHORT_RESET, LONG_RESET, HDR_MARK_RESET, HDR_SPACE_RESET);
		calm = 1'b1;
		run_traffic(52);

		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/irpde_pkg.sv
rtl/irpde_front.sv
rtl/irpde_cmd_fifo.sv
rtl/irpde_back.sv
rtl/ir_pulse_distance_encoder.sv
rtl/irpde_chk.sv
sim/tb_ir_pulse_distance_encoder.sv
